[design/ifhg_pkg.sv]
// ifhg_pkg: shared constants, types and command/status structs for the
// IPv4 fragment header generator. No dependencies.

package ifhg_pkg;

  // Largest payload carried by one fragment, before rounding to 8 bytes
  localparam int MaxFragPayload = 1480;
  // Most results produced for one request
  localparam int MaxResults     = 45;

  localparam int FragRaw   = MaxFragPayload - (MaxFragPayload % 8);
  localparam int FragBytes = (FragRaw < 8) ? 8 : FragRaw;
  localparam int CntW      = $clog2(MaxResults);

  localparam logic [15:0] HDR_BYTES    = 16'd20;
  localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [15:0] FRAG_LEN     = 16'(FragBytes);
  localparam logic [CntW-1:0] LAST_IDX = CntW'(MaxResults - 1);
  localparam logic [7:0]  TTL_RESET    = 8'd64;

  // Configuration register indexes
  localparam logic CFG_LOCAL_ADDR = 1'b0;
  localparam logic CFG_TTL        = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture request, take identification
    logic sum;    // build the per-request checksum base
    logic emit;   // load output register with current fragment
  } ifhg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frag_last;  // current fragment is the final result
  } ifhg_sts_t;

endpackage

[design/ifhg_if.sv]
// ifhg_if: stream interfaces for request and fragment result channels.
// Depends on nothing.

interface ifhg_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_bytes;
  logic [31:0] dest_address;
  logic [7:0]  proto_number;

  modport source (output valid, payload_bytes, dest_address, proto_number,
                  input ready);
  modport sink   (input valid, payload_bytes, dest_address, proto_number,
                  output ready);
endinterface

interface ifhg_frag_if;
  logic        valid;
  logic        ready;
  logic [15:0] ident;
  logic [15:0] chunk_start;
  logic [10:0] chunk_bytes;
  logic [12:0] offset_units;
  logic        more_frags;
  logic [10:0] total_length;
  logic [15:0] header_sum;
  logic        last;

  modport source (output valid, ident, chunk_start, chunk_bytes, offset_units,
                  more_frags, total_length, header_sum, last,
                  input ready);
  modport sink   (input valid, ident, chunk_start, chunk_bytes, offset_units,
                  more_frags, total_length, header_sum, last,
                  output ready);
endinterface

[design/ipv4_fragment_header_generator.sv]
// Channel   Dir  Modport             Transfer carries
// in_i      in   ifhg_req_if.sink    payload_bytes, dest_address, proto_number
// out_o     out  ifhg_frag_if.source one fragment header result per transfer
// cfg       in   cfg_we_i/idx/wdata  0: local_address, 1: time_to_live
//
// A request is accepted, then its checksum base is built, then its N
// fragments go out, one per cycle while the output does not stall, with
// N = ceil(len/1480) (at least 1, at most 45). The fragment walker's single
// subtract/compare and checksum fold set the one-fragment-per-cycle pace.
// Reset (rst_ni, async, active low) clears the ident counter, TTL to 64,
// source address to 0 and empties the output register.
// Output stalls hold the walker; a new request is taken once the last
// fragment of the previous one has been loaded into the output register.
//
// Top level of the IPv4 fragment header generator. Depends on ifhg_pkg,
// ifhg_if, ifhg_ctrl and ifhg_dp.

module ipv4_fragment_header_generator import ifhg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  ifhg_req_if.sink    in_i,
  ifhg_frag_if.source out_o
);

  ifhg_cmd_t cmd;
  ifhg_sts_t sts;

  // Controller: request acceptance, sequencing, output valid
  ifhg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: config, ident counter, fragment walk, checksum, result register
  ifhg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .payload_bytes_i (in_i.payload_bytes),
    .dest_address_i  (in_i.dest_address),
    .proto_number_i  (in_i.proto_number),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .ident_o         (out_o.ident),
    .chunk_start_o   (out_o.chunk_start),
    .chunk_bytes_o   (out_o.chunk_bytes),
    .offset_units_o  (out_o.offset_units),
    .more_frags_o    (out_o.more_frags),
    .total_length_o  (out_o.total_length),
    .header_sum_o    (out_o.header_sum),
    .last_o          (out_o.last)
  );

endmodule

[design/ifhg_ctrl.sv]
// ifhg_ctrl: sequencing state machine and output valid flag.
// Depends on ifhg_pkg.

module ifhg_ctrl import ifhg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ifhg_sts_t sts_i,
  output ifhg_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.frag_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/ifhg_dp.sv]
// ifhg_dp: config registers, identification counter, fragment walker,
// checksum arithmetic and output register. Depends on ifhg_pkg.

module ifhg_dp import ifhg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [15:0] payload_bytes_i,
  input  logic [31:0] dest_address_i,
  input  logic [7:0]  proto_number_i,
  input  ifhg_cmd_t   cmd_i,
  output ifhg_sts_t   sts_o,
  output logic [15:0] ident_o,
  output logic [15:0] chunk_start_o,
  output logic [10:0] chunk_bytes_o,
  output logic [12:0] offset_units_o,
  output logic        more_frags_o,
  output logic [10:0] total_length_o,
  output logic [15:0] header_sum_o,
  output logic        last_o
);

  logic [31:0]     loc_addr_q;
  logic [7:0]      ttl_q;
  logic [15:0]     ident_ctr_q;
  logic [15:0]     len_q, id_q, base_q, start_q;
  logic [31:0]     dst_q;
  logic [7:0]      proto_q;
  logic [CntW-1:0] cnt_q;

  // output register
  logic [15:0] ident_q, chunk_start_q, header_sum_q;
  logic [10:0] chunk_bytes_q, total_length_q;
  logic [12:0] offset_units_q;
  logic        more_frags_q, last_q;

  // per-request constant part of the header sum
  logic [18:0] base_sum;
  logic [16:0] base_f1;
  logic [15:0] base_f2;

  // current fragment
  logic [15:0] remain, chunk16, tot16, flags;
  logic        mf, frag_last;
  logic [17:0] frag_sum;
  logic [16:0] frag_f1;
  logic [15:0] frag_f2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_addr_q <= '0;
      ttl_q      <= TTL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCAL_ADDR: loc_addr_q <= cfg_wdata_i;
        CFG_TTL:        ttl_q      <= cfg_wdata_i[7:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_ctr_q <= '0;
    end else if (cmd_i.load) begin
      ident_ctr_q <= ident_ctr_q + 16'd1;
    end
  end

  // end-around carry: two folds bring any sum of up to 8 words into 16 bits
  assign base_sum = 19'(VER_IHL_TOS) + 19'(id_q) + 19'({ttl_q, proto_q})
                  + 19'(loc_addr_q[31:16]) + 19'(loc_addr_q[15:0])
                  + 19'(dst_q[31:16]) + 19'(dst_q[15:0]);
  assign base_f1  = 17'(base_sum[15:0]) + 17'(base_sum[18:16]);
  assign base_f2  = base_f1[15:0] + 16'(base_f1[16]);

  assign remain    = len_q - start_q;
  assign mf        = (remain > FRAG_LEN);
  assign chunk16   = mf ? FRAG_LEN : remain;
  assign tot16     = HDR_BYTES + chunk16;
  assign flags     = {2'b00, mf, start_q[15:3]};
  assign frag_last = !mf || (cnt_q == LAST_IDX);

  assign frag_sum = 18'(base_q) + 18'(tot16) + 18'(flags);
  assign frag_f1  = 17'(frag_sum[15:0]) + 17'(frag_sum[17:16]);
  assign frag_f2  = frag_f1[15:0] + 16'(frag_f1[16]);

  assign sts_o.frag_last = frag_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.emit && !frag_last) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q   <= payload_bytes_i;
      dst_q   <= dest_address_i;
      proto_q <= proto_number_i;
      id_q    <= ident_ctr_q;
      start_q <= '0;
    end else if (cmd_i.emit) begin
      start_q <= start_q + chunk16;
    end
    if (cmd_i.sum) base_q <= base_f2;
    if (cmd_i.emit) begin
      ident_q        <= id_q;
      chunk_start_q  <= start_q;
      chunk_bytes_q  <= chunk16[10:0];
      offset_units_q <= start_q[15:3];
      more_frags_q   <= mf;
      total_length_q <= tot16[10:0];
      header_sum_q   <= ~frag_f2;
      last_q         <= frag_last;
    end
  end

  assign ident_o        = ident_q;
  assign chunk_start_o  = chunk_start_q;
  assign chunk_bytes_o  = chunk_bytes_q;
  assign offset_units_o = offset_units_q;
  assign more_frags_o   = more_frags_q;
  assign total_length_o = total_length_q;
  assign header_sum_o   = header_sum_q;
  assign last_o         = last_q;

endmodule

[design/ifhg_chk.sv]
// ifhg_chk: port-level checks for the fragment header generator, bound to
// the top level. Depends on ifhg_pkg.

module ifhg_chk import ifhg_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] ident,
  input logic [15:0] chunk_start,
  input logic [10:0] chunk_bytes,
  input logic [12:0] offset_units,
  input logic        more_frags,
  input logic [10:0] total_length,
  input logic        last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(ident) && $stable(chunk_start))
    else $error("result changed while stalled");

  // one request at a time
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted in consecutive cycles");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> total_length == chunk_bytes + 11'(HDR_BYTES))
    else $error("total length mismatch");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && more_frags |-> chunk_bytes == FRAG_LEN[10:0]
                                && offset_units == chunk_start[15:3])
    else $error("non-final fragment not full size");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !more_frags |-> last)
    else $error("final fragment not flagged last");

endmodule

bind ipv4_fragment_header_generator ifhg_chk u_ifhg_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .ident        (out_o.ident),
  .chunk_start  (out_o.chunk_start),
  .chunk_bytes  (out_o.chunk_bytes),
  .offset_units (out_o.offset_units),
  .more_frags   (out_o.more_frags),
  .total_length (out_o.total_length),
  .last         (out_o.last)
);

[test/tb_ipv4_fragment_header_generator.sv]
// Self-checking bench for ipv4_fragment_header_generator: a request driver,
// a fragment monitor and an in-bench header predictor.
// Depends on ifhg_pkg, ifhg_if and the design sources.
`timescale 1ns / 100ps

module tb_ipv4_fragment_header_generator;
  import ifhg_pkg::*;

  localparam int          STALL_LIMIT  = 2000;  // cycles without a transfer
  localparam int          DRAIN_CYCLES = 8;     // pause after the last fragment
  localparam logic [15:0] MF_FLAG      = 16'h2000;

  typedef struct {
    logic [15:0] payload_bytes;
    logic [31:0] dest_address;
    logic [7:0]  proto_number;
  } pkt_req_t;

  typedef struct {
    logic [15:0] ident;
    logic [15:0] chunk_start;
    logic [10:0] chunk_bytes;
    logic [12:0] offset_units;
    logic        more_frags;
    logic [10:0] total_length;
    logic [15:0] header_sum;
    logic        last;
  } frag_hdr_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  ifhg_req_if  req_if ();
  ifhg_frag_if frag_if ();

  ipv4_fragment_header_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (frag_if)
  );

  // Requests waiting to be driven, and fragment headers still owed by the block
  pkt_req_t  pkt_req_q[$];
  frag_hdr_t frag_hdr_expect_q[$];

  // Shadow of the block's registers and identification counter
  logic [31:0] src_addr_shadow;
  logic [7:0]  ttl_shadow;
  logic [15:0] next_ident = 16'd0;

  int error_cnt    = 0;
  int stall_cycles = 0;
  bit req_idle_on;   // random gaps between requests
  bit rsp_idle_on;   // random back-pressure on the fragment channel

  // ---------------------------------------------------------------------------
  // Clock and the single reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  // Half back-to-back, some short gaps, the odd long one
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (!enabled || sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Payload lengths biased towards fragment boundaries and the top of range
  function automatic logic [15:0] pick_payload();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 16'($urandom_range(0, 1480));
    if (sel < 70) return 16'($urandom_range(1481, 9000));
    if (sel < 82) return 16'($urandom());
    if (sel < 94) begin
      k = $urandom_range(1, 44);
      return 16'(k * 1480 + $urandom_range(0, 2) - 1);
    end
    return 16'($urandom_range(65500, 65535));
  endfunction

  function automatic logic [31:0] pick_dest();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // One's-complement sum over the 20-byte header; the checksum word itself
  // counts as zero
  function automatic logic [15:0] ip_header_checksum(input logic [15:0] tot_len,
                                                     input logic [15:0] id,
                                                     input logic [15:0] flags,
                                                     input logic [7:0]  proto,
                                                     input logic [31:0] dst);
    logic [15:0] words [9];
    logic [31:0] acc;
    words = '{VER_IHL_TOS, tot_len, id, flags, {ttl_shadow, proto},
              src_addr_shadow[31:16], src_addr_shadow[15:0], dst[31:16], dst[15:0]};
    acc = 32'd0;
    foreach (words[i]) begin
      acc = acc + words[i];
      acc = (acc & 32'h0000_ffff) + (acc >> 16);
    end
    return ~acc[15:0];
  endfunction

  // Expected fragment headers for one accepted request
  task automatic build_fragment_headers(input pkt_req_t r);
    frag_hdr_t   h;
    int unsigned frag_size;
    int unsigned start;
    int unsigned remain;
    int unsigned chunk;
    int unsigned count;
    logic [15:0] flags;
    frag_size = MaxFragPayload & ~7;
    if (frag_size < 8) frag_size = 8;
    start = 0;
    count = 0;
    h.ident = next_ident;
    next_ident = next_ident + 16'd1;
    do begin
      remain         = r.payload_bytes - start;
      h.more_frags   = (remain > frag_size);
      chunk          = h.more_frags ? frag_size : remain;
      h.chunk_start  = 16'(start);
      h.chunk_bytes  = 11'(chunk);
      h.offset_units = 13'(start >> 3);
      h.total_length = 11'(HDR_BYTES + chunk);
      flags          = (h.more_frags ? MF_FLAG : 16'h0000) | 16'(h.offset_units);
      h.header_sum   = ip_header_checksum(16'(HDR_BYTES + chunk), h.ident, flags,
                                          r.proto_number, r.dest_address);
      // Cut short at the result limit, which leaves more_frags set on the last
      h.last         = !h.more_frags || (count == MaxResults - 1);
      frag_hdr_expect_q.push_back(h);
      count++;
      start += chunk;
    end while (!h.last);
  endtask

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      error_cnt++;
    end
  endfunction

  task automatic queue_req(input logic [15:0] len, input logic [31:0] dst,
                           input logic [7:0] proto);
    pkt_req_t r;
    r.payload_bytes = len;
    r.dest_address  = dst;
    r.proto_number  = proto;
    pkt_req_q.push_back(r);
  endtask

  // Register writes only happen with the block idle, so the shadow follows at once
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_LOCAL_ADDR: src_addr_shadow = value;
      CFG_TTL:        ttl_shadow      = value[7:0];
      default: ;
    endcase
  endtask

  // Every request transferred, every fragment received, then a short settle;
  // checked again after the settle in case a request was just being presented
  task automatic wait_drained();
    do begin
      while (pkt_req_q.size() != 0 || req_if.valid || frag_hdr_expect_q.size() != 0)
        @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end while (pkt_req_q.size() != 0 || req_if.valid || frag_hdr_expect_q.size() != 0);
  endtask

  // Field extremes, fragment boundaries, empty payload, out-of-range lengths
  task automatic queue_directed();
    queue_req(16'd0,     32'h0000_0000, 8'h00);   // empty payload
    queue_req(16'd1,     32'hffff_ffff, 8'hff);
    queue_req(16'd7,     32'h1234_5678, 8'd6);
    queue_req(16'd8,     32'hc0a8_0101, 8'd17);
    queue_req(16'd1479,  32'h0a00_0001, 8'd1);
    queue_req(16'd1480,  32'h0a00_0002, 8'd6);    // exactly one full fragment
    queue_req(16'd1481,  32'h0a00_0003, 8'd17);   // one byte spills over
    queue_req(16'd2960,  32'h7f00_0001, 8'd6);
    queue_req(16'd2961,  32'h8000_0000, 8'd17);
    queue_req(16'h5555,  32'haaaa_aaaa, 8'h55);
    queue_req(16'haaaa,  32'h5555_5555, 8'haa);
    queue_req(16'd65120, 32'hdead_beef, 8'd50);   // 44 full fragments
    queue_req(16'd65515, 32'hffff_fffe, 8'd47);   // top of the legal range
    queue_req(16'd65516, 32'h0000_0001, 8'd132);  // above range
    queue_req(16'd65535, 32'hffff_ffff, 8'hff);   // most fragments
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: presents the head of pkt_req_q, holds it until the
  // transfer, and predicts the fragments at the edge of the transfer
  // ---------------------------------------------------------------------------
  pkt_req_t    req_cur;
  int unsigned req_gap = 0;
  bit          req_busy;

  initial begin
    req_if.valid         = 1'b0;
    req_if.payload_bytes = '0;
    req_if.dest_address  = '0;
    req_if.proto_number  = '0;
    frag_if.ready        = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_LOCAL_ADDR;
    cfg_wdata_i          = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_busy = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        build_fragment_headers(req_cur);
        req_busy = 1'b0;
      end
      // One assignment to valid per edge: a back-to-back request keeps it high
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (pkt_req_q.size() != 0) begin
          req_cur = pkt_req_q.pop_front();
          req_if.valid         <= 1'b1;
          req_if.payload_bytes <= req_cur.payload_bytes;
          req_if.dest_address  <= req_cur.dest_address;
          req_if.proto_number  <= req_cur.proto_number;
          req_gap = pick_gap(req_idle_on);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fragment monitor: random back-pressure, each transfer checked against the
  // oldest outstanding header
  // ---------------------------------------------------------------------------
  int unsigned rsp_stall = 0;
  frag_hdr_t   want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frag_if.valid && frag_if.ready) begin
        if (frag_hdr_expect_q.size() == 0) begin
          $display("%0t: unexpected fragment: expected none, actual ident %0d start %0d",
                   $time, frag_if.ident, frag_if.chunk_start);
          error_cnt++;
        end else begin
          want = frag_hdr_expect_q.pop_front();
          check_field("ident",        want.ident,        frag_if.ident);
          check_field("chunk_start",  want.chunk_start,  frag_if.chunk_start);
          check_field("chunk_bytes",  want.chunk_bytes,  frag_if.chunk_bytes);
          check_field("offset_units", want.offset_units, frag_if.offset_units);
          check_field("more_frags",   want.more_frags,   frag_if.more_frags);
          check_field("total_length", want.total_length, frag_if.total_length);
          check_field("header_sum",   want.header_sum,   frag_if.header_sum);
          check_field("last",         want.last,         frag_if.last);
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        frag_if.ready <= 1'b0;
      end else begin
        frag_if.ready <= 1'b1;
        rsp_stall = pick_gap(rsp_idle_on);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a transfer on either channel means a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (frag_if.valid && frag_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then phases of requests under different register
  // settings; registers are only touched once the block has drained
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    src_addr_shadow = 32'h0000_0000;
    ttl_shadow      = TTL_RESET;
    req_idle_on     = 1'b1;
    rsp_idle_on     = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) wait_drained();
      case (ph)
        0: ;  // reset values: source 0, TTL 64
        1: begin
          write_reg(CFG_LOCAL_ADDR, 32'hffff_ffff);
          write_reg(CFG_TTL, 32'd255);
        end
        2: begin
          write_reg(CFG_LOCAL_ADDR, 32'h0000_0000);
          write_reg(CFG_TTL, 32'd0);
        end
        5: begin
          write_reg(CFG_LOCAL_ADDR, 32'hc0a8_0001);
          write_reg(CFG_TTL, 32'd64);
        end
        default: begin
          // Upper data bits are junk for the TTL register
          write_reg(CFG_LOCAL_ADDR, $urandom());
          write_reg(CFG_TTL, $urandom());
        end
      endcase
      // Phase 4 runs flat out on both sides
      req_idle_on = (ph != 4) && (ph != 2 || $urandom_range(0, 1));
      rsp_idle_on = (ph != 4);
      if (ph < 2) queue_directed();
      repeat ((ph == 0 || ph == 5) ? 25 : 35)
        queue_req(pick_payload(), pick_dest(), 8'($urandom_range(0, 255)));
    end

    wait_drained();
    if (error_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
